### hw/rtl/jsv_pkg.sv
// jsv_pkg: types, codes and character constants for the method descriptor checker
// no dependencies; used by every other file under hw/rtl
package jsv_pkg;

  localparam int unsigned CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;  // (
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;  // )
  localparam logic [CHAR_W-1:0] CH_CLASS = 8'h4C;  // L
  localparam logic [CHAR_W-1:0] CH_ARRAY = 8'h5B;  // [
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;  // ;
  localparam logic [CHAR_W-1:0] CH_VOID  = 8'h56;  // V
  localparam logic [CHAR_W-1:0] CH_BOOL  = 8'h5A;  // Z
  localparam logic [CHAR_W-1:0] CH_LONG  = 8'h4A;  // J
  localparam logic [CHAR_W-1:0] CH_BYTE  = 8'h42;  // B
  localparam logic [CHAR_W-1:0] CH_CHAR  = 8'h43;  // C
  localparam logic [CHAR_W-1:0] CH_SHORT = 8'h53;  // S
  localparam logic [CHAR_W-1:0] CH_INT   = 8'h49;  // I
  localparam logic [CHAR_W-1:0] CH_FLOAT = 8'h46;  // F
  localparam logic [CHAR_W-1:0] CH_DBL   = 8'h44;  // D
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    EV_PARAM  = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_REJECT = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_OPEN   = 2'd1,
    ERR_PARAM  = 2'd2,
    ERR_RETURN = 2'd3
  } err_t;

  typedef enum logic [6:0] {
    PH_START = 7'b0000001,
    PH_PARAM = 7'b0000010,
    PH_CLASS = 7'b0000100,
    PH_ARRAY = 7'b0001000,
    PH_RET   = 7'b0010000,
    PH_DONE  = 7'b0100000,
    PH_DRAIN = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   in_return;
    logic   name_seen;
  } state_t;

  typedef struct packed {
    event_t            event_res;
    logic [CHAR_W-1:0] kind;
    err_t              error_code;
  } result_t;

  typedef struct packed {
    state_t  st;
    logic    emit;
    result_t res;
  } step_t;

  localparam state_t STATE_RESET = '{phase: PH_START, in_return: 1'b0, name_seen: 1'b0};

  function automatic logic is_primitive(input logic [CHAR_W-1:0] c);
    is_primitive = c inside {CH_BOOL, CH_BYTE, CH_CHAR, CH_SHORT,
                             CH_INT, CH_LONG, CH_FLOAT, CH_DBL};
  endfunction

endpackage

### hw/rtl/jsv_if.sv
// jsv_in_if / jsv_out_if: valid-ready channels for characters and results
// depends on jsv_pkg
interface jsv_in_if;
  logic                          valid;
  logic                          ready;
  logic [jsv_pkg::CHAR_W-1:0]    ch;
  logic                          last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface jsv_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    event_res;
  logic [jsv_pkg::CHAR_W-1:0]    kind;
  logic [1:0]                    error_code;

  modport source (output valid, output event_res, output kind, output error_code, input ready);
  modport sink (input valid, input event_res, input kind, input error_code, output ready);
endinterface

### hw/rtl/jsv_step.sv
// jsv_step: per-character decision, next state and optional result
// depends on jsv_pkg
module jsv_step (
  input  jsv_pkg::state_t              cur,
  input  logic [jsv_pkg::CHAR_W-1:0]   ch,
  input  logic                         last,
  output jsv_pkg::step_t               step
);

  function automatic jsv_pkg::step_t no_emit(input jsv_pkg::state_t s);
    jsv_pkg::step_t r;
    r.st             = s;
    r.emit           = 1'b0;
    r.res.event_res  = jsv_pkg::EV_PARAM;
    r.res.kind       = jsv_pkg::CH_NUL;
    r.res.error_code = jsv_pkg::ERR_NONE;
    return r;
  endfunction

  function automatic jsv_pkg::step_t fail(input jsv_pkg::state_t s, input jsv_pkg::err_t code,
                                          input logic lst);
    jsv_pkg::step_t r;
    r                = no_emit(s);
    r.emit           = 1'b1;
    r.res.event_res  = jsv_pkg::EV_REJECT;
    r.res.error_code = code;
    if (lst) begin
      r.st = jsv_pkg::STATE_RESET;
    end else begin
      r.st.phase = jsv_pkg::PH_DRAIN;
    end
    return r;
  endfunction

  function automatic jsv_pkg::err_t type_error(input jsv_pkg::state_t s);
    return s.in_return ? jsv_pkg::ERR_RETURN : jsv_pkg::ERR_PARAM;
  endfunction

  function automatic jsv_pkg::step_t finish_type(input jsv_pkg::state_t s,
                                                 input logic [jsv_pkg::CHAR_W-1:0] k,
                                                 input logic lst);
    jsv_pkg::step_t r;
    r = no_emit(s);
    if (s.in_return) begin
      if (lst) begin
        r.emit          = 1'b1;
        r.res.event_res = jsv_pkg::EV_ACCEPT;
        r.res.kind      = k;
        r.st            = jsv_pkg::STATE_RESET;
      end else begin
        r.st.phase = jsv_pkg::PH_DONE;
      end
    end else if (lst) begin
      r = fail(s, jsv_pkg::ERR_RETURN, 1'b1);
    end else begin
      r.st.phase      = jsv_pkg::PH_PARAM;
      r.emit          = 1'b1;
      r.res.event_res = jsv_pkg::EV_PARAM;
      r.res.kind      = k;
    end
    return r;
  endfunction

  function automatic jsv_pkg::step_t open_class(input jsv_pkg::state_t s, input logic lst);
    jsv_pkg::state_t n;
    jsv_pkg::step_t  r;
    n           = s;
    n.phase     = jsv_pkg::PH_CLASS;
    n.name_seen = 1'b0;
    r           = no_emit(n);
    if (lst) begin
      r = fail(n, type_error(n), 1'b1);
    end
    return r;
  endfunction

  function automatic jsv_pkg::step_t type_start(input jsv_pkg::state_t s,
                                                input logic [jsv_pkg::CHAR_W-1:0] c,
                                                input logic lst);
    jsv_pkg::state_t n;
    jsv_pkg::step_t  r;
    n       = s;
    n.phase = jsv_pkg::PH_ARRAY;
    if (jsv_pkg::is_primitive(c) || (c == jsv_pkg::CH_VOID && s.in_return)) begin
      r = finish_type(s, c, lst);
    end else if (c == jsv_pkg::CH_CLASS) begin
      r = open_class(s, lst);
    end else if (c == jsv_pkg::CH_ARRAY) begin
      r = lst ? fail(n, type_error(n), 1'b1) : no_emit(n);
    end else begin
      r = fail(s, type_error(s), lst);
    end
    return r;
  endfunction

  jsv_pkg::state_t tmp;

  always_comb begin
    tmp  = cur;
    step = no_emit(cur);
    case (cur.phase)
      jsv_pkg::PH_START: begin
        if (ch != jsv_pkg::CH_OPEN) begin
          step = fail(cur, jsv_pkg::ERR_OPEN, last);
        end else begin
          tmp.phase     = jsv_pkg::PH_PARAM;
          tmp.in_return = 1'b0;
          step = last ? fail(tmp, jsv_pkg::ERR_RETURN, 1'b1) : no_emit(tmp);
        end
      end
      jsv_pkg::PH_PARAM: begin
        if (ch == jsv_pkg::CH_CLOSE) begin
          tmp.phase     = jsv_pkg::PH_RET;
          tmp.in_return = 1'b1;
          step = last ? fail(tmp, jsv_pkg::ERR_RETURN, 1'b1) : no_emit(tmp);
        end else begin
          step = type_start(cur, ch, last);
        end
      end
      jsv_pkg::PH_RET: begin
        step = type_start(cur, ch, last);
      end
      jsv_pkg::PH_ARRAY: begin
        if (ch == jsv_pkg::CH_ARRAY) begin
          step = last ? fail(cur, type_error(cur), 1'b1) : no_emit(cur);
        end else if (jsv_pkg::is_primitive(ch)) begin
          step = finish_type(cur, jsv_pkg::CH_CLASS, last);
        end else if (ch == jsv_pkg::CH_CLASS) begin
          step = open_class(cur, last);
        end else begin
          step = fail(cur, type_error(cur), last);
        end
      end
      jsv_pkg::PH_CLASS: begin
        if (ch == jsv_pkg::CH_SEMI) begin
          step = cur.name_seen ? finish_type(cur, jsv_pkg::CH_CLASS, last)
                               : fail(cur, type_error(cur), last);
        end else begin
          tmp.name_seen = 1'b1;
          step = last ? fail(tmp, type_error(tmp), 1'b1) : no_emit(tmp);
        end
      end
      jsv_pkg::PH_DONE: begin
        step = fail(cur, jsv_pkg::ERR_RETURN, last);
      end
      default: begin
        // drained, and any phase code that means nothing
        step = last ? no_emit(jsv_pkg::STATE_RESET) : no_emit(cur);
      end
    endcase
  end

endmodule

### hw/rtl/jsv_out_reg.sv
// jsv_out_reg: result register driving the output channel
// depends on jsv_pkg and jsv_out_if
module jsv_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  jsv_pkg::result_t  data,
  output logic              space,
  jsv_out_if.source         result
);

  logic             valid;
  jsv_pkg::result_t held;

  // the register can take a new result when empty or when the current one leaves
  assign space = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  assign result.valid      = valid;
  assign result.event_res  = held.event_res;
  assign result.kind       = held.kind;
  assign result.error_code = held.error_code;

endmodule

### hw/rtl/jni_signature_validator.sv
// jni_signature_validator: streamed method descriptor checker, top level
// depends on jsv_pkg, jsv_if, jsv_step and jsv_out_reg
//
//   channel  dir  payload                      transaction
//   item     in   ch[7:0], last                valid & ready
//   result   out  event_res, kind, error_code  valid & ready
//
// one character per cycle sustained while the result register has space; a result reaches the port
// through the input register, then decision logic into the result register
// the parser state updates in the same cycle as the result register
// a character that yields no result moves on even while the result register is full
// synchronous reset empties both registers and returns the parser to the opening state
module jni_signature_validator (
  input  logic       clk,
  input  logic       rst,
  jsv_in_if.sink     item,
  jsv_out_if.source  result
);

  logic                       s1_valid;
  logic [jsv_pkg::CHAR_W-1:0] s1_ch;
  logic                       s1_last;
  jsv_pkg::state_t            state;
  jsv_pkg::step_t             step;
  logic                       space;
  logic                       advance;

  jsv_step u_step (
    .cur  (state),
    .ch   (s1_ch),
    .last (s1_last),
    .step (step)
  );

  assign advance    = s1_valid && (!step.emit || space);
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_ch   <= item.ch;
      s1_last <= item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jsv_pkg::STATE_RESET;
    end else if (advance) begin
      state <= step.st;
    end
  end

  jsv_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && step.emit),
    .data   (step.res),
    .space  (space),
    .result (result)
  );

endmodule
